FILE: sv/sgled_pkg.sv
// Shared types and constants for the SGPIO drive LED pattern decoder.
// Holds the channel payload structs, the LED mode codes and default timing values.
// Depends on nothing; every other file of the block but the stream interface refers to it by scoped names.
package sgled_pkg;

    // Fixed geometry of the backplane decode.
    localparam int SLOT_COUNT  = 8;
    localparam int GROUP_COUNT = 4;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int GROUP_W     = $clog2(GROUP_COUNT);
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_BITS_PER_SLOT       = 3;
    localparam int DEF_SLOW_HALF_PERIOD_MS = 500;
    localparam int DEF_FAST_HALF_PERIOD_MS = 125;

    // Value of the last applied time after reset.
    localparam logic [TIME_W-1:0] TIME_RESET = '1;

    // Input beat kinds.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    // LED modes, ordered so that a larger code wins a merge.
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_SLOW = 2'd2,
        MODE_FAST = 2'd3
    } mode_t;

    // One input beat: a time tick or a decoded frame.
    typedef struct packed {
        logic               func;
        logic [TIME_W-1:0]  now_ms;
        logic               frame_valid;
        logic               frame_overflow;
        logic [COUNT_W-1:0] frame_bits;
        logic [SLOT_COUNT-1:0] act_bits;
        logic [SLOT_COUNT-1:0] locate_bits;
        logic [SLOT_COUNT-1:0] fail_bits;
    } in_item_t;

    // One result beat: pin levels for the four LED groups.
    typedef struct packed {
        logic [GROUP_COUNT-1:0] activity_pins;
        logic [GROUP_COUNT-1:0] status_pins;
    } out_item_t;

endpackage

FILE: sv/sgled_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; the block uses the structs of sgled_pkg.
interface sgled_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: sv/sgled_mode_decode.sv
// Per-group LED mode decode of one SGPIO frame.
// Purely combinational; uses the mode codes and geometry from sgled_pkg.
module sgled_mode_decode #(
    parameter int BITS_PER_SLOT = sgled_pkg::DEF_BITS_PER_SLOT
) (
    input  logic                                   half_select,
    input  logic [sgled_pkg::COUNT_W-1:0]          frame_bits,
    input  logic [sgled_pkg::SLOT_COUNT-1:0]       act_bits,
    input  logic [sgled_pkg::SLOT_COUNT-1:0]       locate_bits,
    input  logic [sgled_pkg::SLOT_COUNT-1:0]       fail_bits,
    output sgled_pkg::mode_t                       act_mode [sgled_pkg::GROUP_COUNT],
    output sgled_pkg::mode_t                       sta_mode [sgled_pkg::GROUP_COUNT]
);

    logic [sgled_pkg::SLOT_COUNT-1:0] slot_live;

    // A slot counts only if its bits fit inside the received frame. The limit
    // grows with the slot number, so a cut slot also cuts every later one.
    for (genvar s = 0; s < sgled_pkg::SLOT_COUNT; s++) begin : g_live
        assign slot_live[s] =
            frame_bits > sgled_pkg::COUNT_W'(s * BITS_PER_SLOT + 2);
    end

    // Each group is fed by exactly one slot of the selected half, so the
    // merge against cleared modes reduces to the slot's own decode.
    always_comb
    begin
        logic [sgled_pkg::SLOT_W-1:0] s;
        logic                         live;
        logic                         a;
        logic                         loc;
        logic                         f;
        for (int g = 0; g < sgled_pkg::GROUP_COUNT; g++)
        begin
            s    = {half_select, sgled_pkg::GROUP_W'(g)};
            live = slot_live[s];
            a    = act_bits[s];
            loc  = locate_bits[s];
            f    = fail_bits[s];
            act_mode[g] = sgled_pkg::MODE_OFF;
            sta_mode[g] = sgled_pkg::MODE_OFF;
            if (live)
            begin
                if (loc && !f)
                begin
                    act_mode[g] = sgled_pkg::MODE_FAST;
                    sta_mode[g] = sgled_pkg::MODE_FAST;
                end
                else if (!loc && f)
                begin
                    sta_mode[g] = sgled_pkg::MODE_ON;
                end
                else if (loc && f)
                begin
                    sta_mode[g] = sgled_pkg::MODE_SLOW;
                end
                else if (a)
                begin
                    act_mode[g] = sgled_pkg::MODE_FAST;
                end
                else
                begin
                    act_mode[g] = sgled_pkg::MODE_ON;
                end
            end
        end
    end

endmodule

FILE: sv/sgled_phase_div.sv
// Blink phase unit: parity of the millisecond time divided by a half period.
// Uses a reciprocal multiply registered in one stage and a wide add in the next.
// Depends on sgled_pkg for the time width.
module sgled_phase_div #(
    parameter int DIVISOR = sgled_pkg::DEF_SLOW_HALF_PERIOD_MS
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [sgled_pkg::TIME_W-1:0] t_in,
    input  logic [sgled_pkg::TIME_W-1:0] t_held,
    output logic                         odd
);

    localparam int TW    = sgled_pkg::TIME_W;
    localparam int SHIFT = $clog2(DIVISOR);

    // Low word of the rounded-up reciprocal; the implicit top bit is 2^TW.
    localparam logic [2*TW-1:0] MAGIC_FULL =
        (((64'd1 << TW) * ((64'd1 << SHIFT) - 64'(DIVISOR))) / 64'(DIVISOR)) + 64'd1;
    localparam logic [TW-1:0] MAGIC = MAGIC_FULL[TW-1:0];

    logic [2*TW-1:0] prod_reg;
    logic [2*TW-1:0] prod_next;
    logic [2*TW:0]   sum;

    assign prod_next = t_in * MAGIC;

    // Product of the time and the low reciprocal word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Adding the time at the implicit top bit gives the exact quotient;
    // only its lowest bit is needed.
    assign sum = {1'b0, t_held, {TW{1'b0}}} + {1'b0, prod_reg};
    assign odd = sum[TW + SHIFT];

endmodule

FILE: sv/sgpio_drive_led_pattern_decoder.sv
// Top level of the SGPIO drive LED pattern decoder: LED mode state and pipeline.
// Depends on sgled_pkg, sgled_stream_if, sgled_mode_decode and sgled_phase_div.
//
//   channel   dir   payload        handshake
//   item      in    in_item_t      valid/ready
//   result    out   out_item_t     valid/ready
//   wr_*      in    half select    write enable, no wait
//
// Three register stages: input, state/multiply, result. A beat passes from the input
// stage through the state/multiply stage to the result stage; one beat can enter every cycle unless result stalls.
// The split comes from the reciprocal multipliers of the blink phase units.
// Each stage holds on its own under back-pressure, so empty stages still fill.
// Reset sets all LED modes off, the last applied time to all ones and the half
// select to zero; there is no clearing pass.
module sgpio_drive_led_pattern_decoder #(
    parameter int BITS_PER_SLOT       = sgled_pkg::DEF_BITS_PER_SLOT,
    parameter int SLOW_HALF_PERIOD_MS = sgled_pkg::DEF_SLOW_HALF_PERIOD_MS,
    parameter int FAST_HALF_PERIOD_MS = sgled_pkg::DEF_FAST_HALF_PERIOD_MS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sgled_stream_if.sink         item,
    sgled_stream_if.source       result,
    input  logic                 wr_en,
    input  logic                 wr_data
);

    localparam int GC = sgled_pkg::GROUP_COUNT;
    localparam int TW = sgled_pkg::TIME_W;

    // Configuration.
    logic half_select_reg;

    // Stage enables.
    logic a_en;
    logic b_en;
    logic out_en;

    // Input stage.
    logic                 a_valid_reg;
    sgled_pkg::in_item_t  a_item_reg;

    // State/multiply stage.
    logic                 b_valid_reg;
    logic [TW-1:0]        b_t_reg;

    // Result stage.
    logic                 out_valid_reg;
    sgled_pkg::out_item_t out_item_reg;
    sgled_pkg::out_item_t out_item_next;

    // LED state.
    sgled_pkg::mode_t     act_mode_reg [GC];
    sgled_pkg::mode_t     sta_mode_reg [GC];
    logic [TW-1:0]        last_time_reg;

    sgled_pkg::mode_t     dec_act_mode [GC];
    sgled_pkg::mode_t     dec_sta_mode [GC];

    logic is_frame;
    logic frame_ok;
    logic tick_new;
    logic emit;
    logic a_fire;
    logic slow_odd;
    logic fast_odd;

    // A blink mode is lit during even half periods.
    function automatic logic lit_f(
        input sgled_pkg::mode_t m,
        input logic             slow_odd_i,
        input logic             fast_odd_i
    );
        logic r;
        unique case (m)
            sgled_pkg::MODE_ON:   r = 1'b1;
            sgled_pkg::MODE_SLOW: r = !slow_odd_i;
            sgled_pkg::MODE_FAST: r = !fast_odd_i;
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    // Each stage loads when it is empty or its contents move on.
    assign out_en     = !out_valid_reg || result.ready;
    assign b_en       = !b_valid_reg || out_en;
    assign a_en       = !a_valid_reg || b_en;
    assign item.ready = a_en;

    // Half select register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_select_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            half_select_reg <= wr_data;
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_item_reg <= item.payload;
        end
    end

    // Frame decode into fresh per-group modes.
    sgled_mode_decode #(
        .BITS_PER_SLOT (BITS_PER_SLOT)
    ) u_decode (
        .half_select (half_select_reg),
        .frame_bits  (a_item_reg.frame_bits),
        .act_bits    (a_item_reg.act_bits),
        .locate_bits (a_item_reg.locate_bits),
        .fail_bits   (a_item_reg.fail_bits),
        .act_mode    (dec_act_mode),
        .sta_mode    (dec_sta_mode)
    );

    // A good frame always answers; a tick answers only at a new time.
    assign is_frame = a_item_reg.func == sgled_pkg::FUNC_FRAME;
    assign frame_ok = is_frame && a_item_reg.frame_valid && !a_item_reg.frame_overflow;
    assign tick_new = !is_frame && (a_item_reg.now_ms != last_time_reg);
    assign emit     = frame_ok || tick_new;
    assign a_fire   = a_valid_reg && b_en;

    // LED state; it changes only as a beat moves on, so the next stage
    // sees the state that its beat left while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GC; g++)
            begin
                act_mode_reg[g] <= sgled_pkg::MODE_OFF;
                sta_mode_reg[g] <= sgled_pkg::MODE_OFF;
            end
            last_time_reg <= sgled_pkg::TIME_RESET;
        end
        else if (a_fire)
        begin
            if (frame_ok)
            begin
                for (int g = 0; g < GC; g++)
                begin
                    act_mode_reg[g] <= dec_act_mode[g];
                    sta_mode_reg[g] <= dec_sta_mode[g];
                end
            end
            if (emit)
            begin
                last_time_reg <= a_item_reg.now_ms;
            end
        end
    end

    // State/multiply stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            b_valid_reg <= a_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            b_t_reg <= a_item_reg.now_ms;
        end
    end

    // Blink phases for the slow and fast half periods.
    sgled_phase_div #(
        .DIVISOR (SLOW_HALF_PERIOD_MS)
    ) u_slow (
        .clk    (clk),
        .load   (b_en),
        .t_in   (a_item_reg.now_ms),
        .t_held (b_t_reg),
        .odd    (slow_odd)
    );

    sgled_phase_div #(
        .DIVISOR (FAST_HALF_PERIOD_MS)
    ) u_fast (
        .clk    (clk),
        .load   (b_en),
        .t_in   (a_item_reg.now_ms),
        .t_held (b_t_reg),
        .odd    (fast_odd)
    );

    // Pin levels: activity is active high, status active low.
    always_comb
    begin
        for (int g = 0; g < GC; g++)
        begin
            out_item_next.activity_pins[g] = lit_f(act_mode_reg[g], slow_odd, fast_odd);
            out_item_next.status_pins[g]   = !lit_f(sta_mode_reg[g], slow_odd, fast_odd);
        end
    end

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // A beat waiting in the middle stage carries the time it applied.
    a_b_time: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_t_reg == last_time_reg))
        else $error("middle-stage beat time differs from last applied time");

    // A tick at the time already applied gives no result.
    a_repeat_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && !is_frame && (a_item_reg.now_ms == last_time_reg)) |=> !b_valid_reg)
        else $error("repeated tick produced a result");

    // A rejected frame leaves the group 0 modes and the time alone and gives nothing.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && is_frame && !frame_ok) |=>
            (!b_valid_reg && $stable(last_time_reg)
             && $stable(act_mode_reg[0]) && $stable(sta_mode_reg[0])))
        else $error("rejected frame changed state or produced a result");

    // With the result stage empty the block always takes a beat.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> item.ready)
        else $error("input stalled with an empty result stage");

endmodule
